// ===== sv/sfcd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfcd_pkg
// Shared types and constants for the frame channel decoder.
// ----------------------------------------------------------------------------
package sfcd_pkg;

  localparam int unsigned WinBytes   = 25;  // sliding window length
  localparam int unsigned NumCh      = 16;  // channels per frame
  localparam int unsigned ChBits     = 11;  // bits per channel value
  localparam int unsigned PayBytes   = 22;  // frame bytes 1..22 carry channel data
  localparam int unsigned FrameBits  = PayBytes * 8;

  localparam logic [7:0] HdrByte = 8'h0F;
  localparam logic [7:0] EndByte = 8'h00;

  localparam logic [3:0] LastCh  = 4'(NumCh - 1);

  // Channel payload of one recognised frame: frame byte 1 sits in bits 7:0.
  typedef logic [FrameBits-1:0] frame_t;

  // Status of the frame queue, seen by both the front and the back part.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== sv/sfcd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfcd_front
// Byte window, fill count and frame recognition; pushes matched frames.
// ----------------------------------------------------------------------------
module sfcd_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         rx_byte,
  input  logic               line_idle,
  input  sfcd_pkg::q_status_t q_status,
  output logic               push,
  output sfcd_pkg::frame_t   push_frame
);
  import sfcd_pkg::*;

  // The oldest window byte is never read after a shift, so only the newer
  // 24 bytes are stored: win[i] holds window position i + 1.
  localparam int unsigned StoreBytes = WinBytes - 1;

  logic [7:0] win [StoreBytes];
  logic [4:0] fill_count;
  logic       accept;
  logic       full_next;
  logic       match;

  assign in_ready  = !q_status.full;
  assign accept    = in_valid && in_ready;
  // After the shift the window is full when 24 or more bytes were there.
  assign full_next = fill_count >= 5'(WinBytes - 1);
  // After the shift the oldest window byte is the one now stored at win[0].
  assign match     = full_next && (win[0] == HdrByte) && (rx_byte == EndByte);
  assign push      = accept && !line_idle && match;

  // After the shift, frame byte j is the byte now stored at win[j].
  always_comb begin
    for (int j = 0; j < PayBytes; j++) begin
      push_frame[8*j +: 8] = win[j+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      for (int i = 0; i < StoreBytes; i++) win[i] <= '0;
    end else if (accept) begin
      if (line_idle) begin
        fill_count <= '0;
        for (int i = 0; i < StoreBytes; i++) win[i] <= '0;
      end else begin
        for (int i = 0; i < StoreBytes - 1; i++) win[i] <= win[i+1];
        win[StoreBytes-1] <= rx_byte;
        if (fill_count < 5'(WinBytes)) fill_count <= fill_count + 5'd1;
      end
    end
  end

  a_push_needs_full: assert property (@(posedge clk) disable iff (rst)
    push |-> fill_count >= 5'(WinBytes - 1))
    else $error("frame pushed from a partial window");
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= 5'(WinBytes))
    else $error("fill count above window length");
  a_idle_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && line_idle) |=> fill_count == '0)
    else $error("idle gap did not clear the fill count");

endmodule

// ===== sv/sfcd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfcd_queue
// Short frame queue decoupling recognition from channel unpacking.
// ----------------------------------------------------------------------------
module sfcd_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  sfcd_pkg::frame_t    push_frame,
  input  logic                pop,
  output sfcd_pkg::frame_t    head_frame,
  output sfcd_pkg::q_status_t q_status
);
  import sfcd_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  frame_t          slots [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign q_status.full  = count == CntW'(DEPTH);
  assign q_status.empty = count == '0;
  assign head_frame     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_frame;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + PtrW'(1);
      if (pop)  rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + PtrW'(1);
      if (push && !pop)      count <= count + CntW'(1);
      else if (pop && !push) count <= count - CntW'(1);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!q_status.full || pop))
    else $error("push into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_status.empty)
    else $error("pop from an empty queue");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(DEPTH))
    else $error("queue count above depth");

endmodule

// ===== sv/sfcd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfcd_back
// Unpacks the head frame into sixteen channel words through an output register.
// ----------------------------------------------------------------------------
module sfcd_back (
  input  logic                clk,
  input  logic                rst,
  input  sfcd_pkg::frame_t    head_frame,
  input  sfcd_pkg::q_status_t q_status,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [3:0]          channel_index,
  output logic [10:0]         channel_value,
  output logic                last
);
  import sfcd_pkg::*;

  logic [3:0] ch;
  logic [7:0] bit_pos;
  logic       load;

  // Channel k starts at bit 11k of the payload; the largest start is 165.
  assign bit_pos = 8'(ch) * 8'(ChBits);
  assign load    = !q_status.empty && (!out_valid || out_ready);
  assign pop     = load && (ch == LastCh);

  always_ff @(posedge clk) begin
    if (load) begin
      channel_index <= ch;
      channel_value <= head_frame[bit_pos +: ChBits];
      last          <= ch == LastCh;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      ch        <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        ch        <= ch + 4'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_last_on_final: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == (channel_index == LastCh)))
    else $error("last flag not on the final channel");
  a_index_steps: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last && !q_status.empty)
      |=> out_valid && (channel_index == $past(channel_index) + 4'd1))
    else $error("channel index did not advance within a frame");
  a_pop_after_last: assert property (@(posedge clk) disable iff (rst)
    pop |=> out_valid && last)
    else $error("frame released before its final channel");

endmodule

// ===== sv/sbus_frame_channel_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbus_frame_channel_decoder
// Recognises 25-byte frames in a byte stream and emits sixteen channel words.
// ----------------------------------------------------------------------------
// Received bytes enter a 25-byte sliding window, one word per cycle. Once at
// least 25 bytes have arrived since reset or the last idle gap, a frame is
// recognised whenever the oldest byte is the header 0x0F and the newest is the
// end byte 0x00; every such match counts, overlapping ones included. A word
// with line_idle set clears the window and produces nothing. For each match
// the block emits sixteen words in channel order, each carrying the 11-bit
// value at bits 11k..11k+10 of frame bytes 1 to 22 (little-endian), with last
// set on channel 15. The front part accepts one input word every cycle and
// copies the channel payload of a match into a frame queue of QUEUE_DEPTH
// entries; the back part unpacks the head frame at one output word per cycle
// while the receiver is ready, through an output register, so the first
// channel of a frame passes through a queue slot and then the output register.
// Input words are taken at one per cycle as long as the frame queue has room;
// ready drops only while the queue is full, which happens when matches arrive
// faster than the back part drains them.
// ----------------------------------------------------------------------------
module sbus_frame_channel_decoder #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic        line_idle,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  channel_index,
  output logic [10:0] channel_value,
  output logic        last
);
  import sfcd_pkg::*;

  // Frame handoff between recognition and unpacking.
  logic      push;
  logic      pop;
  frame_t    push_frame;
  frame_t    head_frame;
  q_status_t q_status;

  // Front part: window, fill count and match detection.
  sfcd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .line_idle  (line_idle),
    .q_status   (q_status),
    .push       (push),
    .push_frame (push_frame)
  );

  // Queue of recognised frames; lets the input run while channels drain.
  sfcd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_frame (push_frame),
    .pop        (pop),
    .head_frame (head_frame),
    .q_status   (q_status)
  );

  // Back part: one channel per cycle into the output register while the receiver is ready.
  sfcd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_frame    (head_frame),
    .q_status      (q_status),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .channel_index (channel_index),
    .channel_value (channel_value),
    .last          (last)
  );

  a_ready_tracks_queue: assert property (@(posedge clk) disable iff (rst)
    in_ready == !q_status.full)
    else $error("input ready disagrees with queue room");
  a_idle_no_push: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && line_idle) |-> !push)
    else $error("frame pushed on an idle gap");
  a_pending_drains: assert property (@(posedge clk) disable iff (rst)
    (!q_status.empty && !out_valid) |=> out_valid)
    else $error("queued frame not started");

endmodule

// ===== verif/sbus_frame_channel_decoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbus_frame_channel_decoder_tb
// Self-checking testbench for the frame channel decoder.
// ----------------------------------------------------------------------------
// A scoreboard keeps its own copy of the 25-byte window and fill count. It
// predicts the sixteen channel words of every recognised frame as input words
// are accepted. Each output word is checked against the oldest prediction.
// The stimulus starts with directed frames:
//   - all-ones and all-zero payloads,
//   - overlapping matches,
//   - an ignored idle byte,
//   - a window that is never filled.
// Random frames, broken frames, noise and idle gaps follow, under three
// idling mixes. One burst of back-to-back matches runs against a long
// receiver hold-off, so that the frame queue fills and input stalls.
// ----------------------------------------------------------------------------

import sfcd_pkg::*;

typedef struct packed {
  logic [3:0]  index;
  logic [10:0] value;
  logic        last;
} chan_word_t;

class FrameScoreboard;
  logic [7:0]  window [WinBytes];
  int unsigned fill;
  chan_word_t  expected [$];
  int unsigned errors;

  function new();
    foreach (window[i]) window[i] = 8'h00;
    fill   = 0;
    errors = 0;
  endfunction

  task report(string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    errors++;
  endtask

  // Shifts one accepted word into the window and queues the channel words
  // of a frame when the full window starts with a header and ends with an end byte.
  function void note_word(logic [7:0] rx, logic idle);
    frame_t      payload;
    chan_word_t  w;
    int unsigned i;
    if (idle) begin
      foreach (window[j]) window[j] = 8'h00;
      fill = 0;
      return;
    end
    for (i = 0; i < WinBytes - 1; i++) window[i] = window[i + 1];
    window[WinBytes - 1] = rx;
    if (fill < WinBytes) fill++;
    if (fill < WinBytes || window[0] != HdrByte || window[WinBytes - 1] != EndByte) return;
    for (i = 0; i < PayBytes; i++) payload[8 * i +: 8] = window[i + 1];
    for (i = 0; i < NumCh; i++) begin
      w.index = 4'(i);
      w.value = payload[ChBits * i +: ChBits];
      w.last  = (4'(i) == LastCh);
      expected.push_back(w);
    end
  endfunction

  task check_word(logic [3:0] idx, logic [10:0] val, logic lst);
    chan_word_t w;
    if (expected.size() == 0) begin
      report($sformatf("unexpected word: channel %0d value %0d last %0b", idx, val, lst));
      return;
    end
    w = expected.pop_front();
    if (idx !== w.index)
      report($sformatf("channel_index %0d, expected %0d", idx, w.index));
    if (val !== w.value)
      report($sformatf("channel %0d value %0d, expected %0d", w.index, val, w.value));
    if (lst !== w.last)
      report($sformatf("channel %0d last %0b, expected %0b", w.index, lst, w.last));
  endtask
endclass

module sbus_frame_channel_decoder_tb;

  localparam int unsigned RandomWords   = 240;
  localparam int unsigned HoldOffCycles = 400;   // receiver hold-off under pressure
  localparam int unsigned StallLimit    = 5000;  // cycles with no word moving on either side
  localparam int unsigned DrainCycles   = 20;    // quiet period after the last word

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic [7:0]  rx_byte   = 8'h00;
  logic        line_idle = 1'b0;
  logic        out_ready = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [3:0]  channel_index;
  logic [10:0] channel_value;
  logic        last;

  // Idling mix, in percent of cycles, for each side.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  // The sender bumps hold_requests. The receiver process then serves one
  // hold-off per request and counts the cycles itself.
  int unsigned hold_requests = 0;
  int unsigned holds_served  = 0;
  int unsigned hold_left     = 0;

  int unsigned data_words = 0;  // accepted non-idle words, paces the random part
  int unsigned quiet      = 0;

  FrameScoreboard frames = new();

  always #5 clk = ~clk;

  sbus_frame_channel_decoder dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .rx_byte       (rx_byte),
    .line_idle     (line_idle),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .channel_index (channel_index),
    .channel_value (channel_value),
    .last          (last)
  );

  // Handshakes are sampled at the rising edge. Everything is driven with
  // nonblocking assignments, so these are the values held during the cycle.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) frames.note_word(rx_byte, line_idle);
      if (out_valid && out_ready) frames.check_word(channel_index, channel_value, last);
    end
  end

  // Watchdog: ends the run if no word moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else if (quiet >= StallLimit) begin
      $display("sbus_frame_channel_decoder: mismatch");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Receiver: random back-pressure, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (holds_served != hold_requests) begin
      holds_served <= hold_requests;
      hold_left    <= HoldOffCycles;
      out_ready    <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Offers one word after a random gap and returns once it is accepted.
  // Valid stays high afterwards, so the next call can follow without a
  // bubble. Any caller that pauses must lower valid itself.
  task automatic send_word(logic [7:0] b, logic idle);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    rx_byte   <= b;
    line_idle <= idle;
    do @(posedge clk); while (!in_ready);
    if (!idle) data_words++;
  endtask

  // An idle gap carries a random byte, which the block must ignore.
  task automatic send_idle();
    send_word(8'($urandom_range(0, 255)), 1'b1);
  endtask

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 7))
      0:       return HdrByte;
      1:       return EndByte;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Sends one frame: the header, 22 channel bytes, the flags byte and the end
  // byte. A broken frame either ends on a wrong byte or is cut short by an
  // idle gap. Payloads are sometimes all ones or all zeros, to hit the value
  // extremes on every channel.
  task automatic send_frame(bit broken);
    int unsigned fill_kind;
    int unsigned cut_at;
    int unsigned i;
    logic [7:0]  end_byte;
    fill_kind = $urandom_range(0, 5);
    cut_at    = (broken && $urandom_range(0, 1)) ? $urandom_range(1, 24) : 25;
    end_byte  = (broken && cut_at == 25) ? 8'($urandom_range(1, 255)) : EndByte;
    send_word(HdrByte, 1'b0);
    for (i = 1; i < 24; i++) begin
      if (i == cut_at) begin
        send_idle();
        return;
      end
      case (fill_kind)
        0:       send_word(8'hFF, 1'b0);
        1:       send_word(8'h00, 1'b0);
        default: send_word(8'($urandom_range(0, 255)), 1'b0);
      endcase
    end
    if (cut_at == 24) begin
      send_idle();
      return;
    end
    send_word(end_byte, 1'b0);
  endtask

  // Five headers, 19 bytes, then five end bytes give five overlapping matches
  // on consecutive words. That is 80 channel words at once, far more than the
  // frame queue holds. It is sent while the receiver holds off, so in_ready
  // must drop and the block must stall its input.
  task automatic send_match_burst();
    send_idle();
    hold_requests++;
    repeat (5) send_word(HdrByte, 1'b0);
    repeat (19) send_word(8'($urandom_range(0, 255)), 1'b0);
    repeat (5) send_word(EndByte, 1'b0);
  endtask

  // The sender stops and waits until every predicted channel word has come
  // out. Valid is lowered first, so the next word is a fresh assignment in a
  // later step.
  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (frames.expected.size() != 0) @(posedge clk);
  endtask

  // Random traffic: mostly well-formed frames with random content. Without
  // such frames the decoder never leaves its no-match path. The rest is
  // broken frames, runs of noise that favor the header and end bytes, and
  // idle gaps.
  task automatic run_random(int unsigned target);
    int unsigned stop_at;
    int unsigned pick;
    stop_at = data_words + target;
    while (data_words < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        if ($urandom_range(0, 1)) send_idle();
        send_frame(1'b0);
      end else if (pick < 75) begin
        send_frame(1'b1);
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 8)) send_word(noise_byte(), 1'b0);
      end else begin
        send_idle();
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // An idle word with all byte bits set must be ignored.
    send_word(8'hFF, 1'b1);

    // A frame whose payload is all ones gives 2047 on every channel.
    send_word(HdrByte, 1'b0);
    repeat (23) send_word(8'hFF, 1'b0);
    send_word(EndByte, 1'b0);

    // Overlapping matches: frame byte 1 is also a header. One more end byte
    // therefore matches again, and the second frame is all zeros.
    send_word(HdrByte, 1'b0);
    send_word(HdrByte, 1'b0);
    repeat (22) send_word(8'h00, 1'b0);
    send_word(EndByte, 1'b0);
    send_word(EndByte, 1'b0);

    // Alternating bit pattern across the payload.
    send_word(HdrByte, 1'b0);
    repeat (11) begin
      send_word(8'h55, 1'b0);
      send_word(8'hAA, 1'b0);
    end
    send_word(8'h00, 1'b0);
    send_word(EndByte, 1'b0);

    // A frame one byte short after an idle gap never fills the window.
    send_idle();
    send_word(HdrByte, 1'b0);
    repeat (22) send_word(8'($urandom_range(0, 255)), 1'b0);
    send_word(EndByte, 1'b0);
    send_idle();
    wait_drain();

    // Sender idles often and the receiver more often.
    send_idle_pct = 31;
    recv_idle_pct = 54;
    run_random(RandomWords / 3);

    send_match_burst();
    wait_drain();

    // The other way round.
    send_idle_pct = 54;
    recv_idle_pct = 31;
    run_random(RandomWords / 3);

    // Full rate on both sides.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(RandomWords / 3);

    wait_drain();
    repeat (DrainCycles) @(posedge clk);
    if (frames.errors == 0) begin
      $display("sbus_frame_channel_decoder: match");
    end else begin
      $display("sbus_frame_channel_decoder: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/sfcd_pkg.sv
sv/sfcd_front.sv
sv/sfcd_queue.sv
sv/sfcd_back.sv
sv/sbus_frame_channel_decoder.sv
verif/sbus_frame_channel_decoder_tb.sv
